>>> rtl/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types, constants and helpers shared by the UTF-8 CJK text validator.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8v_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int          CHAR_COUNT_W = 4;
   localparam int          CODEPOINT_W  = 21;
   localparam logic [3:0]  CNT_MAX      = 4'd15;
   localparam logic [3:0]  MIN_CHARS_RESET = 4'd2;
   localparam logic [3:0]  MAX_CHARS_RESET = 4'd8;

   // Register indexes of the configuration port
   localparam logic CSR_MIN_CHARS = 1'b0;
   localparam logic CSR_MAX_CHARS = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_UTF8   = 2'd1,
      STATUS_BAD_LENGTH = 2'd2,
      STATUS_FOREIGN    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BYTE_ASCII,
      BYTE_LEAD2,
      BYTE_LEAD3,
      BYTE_LEAD4,
      BYTE_CONT,
      BYTE_INVALID
   } byte_class_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      status_type       status;
      logic [3:0]       char_count;
   } rsp_item_type;

   // Classified byte: class, payload bits already masked, end-of-text flag
   typedef struct packed {
      byte_class_type cls;
      logic [6:0]     bits;
      logic           last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   function automatic logic in_cjk(input logic [CODEPOINT_W-1:0] cp);
      in_cjk = (cp >= 21'h03400 && cp <= 21'h04DBF) ||
               (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
               (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
               (cp >= 21'h20000 && cp <= 21'h2EBEF);
   endfunction

endpackage

`default_nettype wire

>>> rtl/utf8v_front.sv
// ----------------------------------------------------------------------------
// utf8v_front
// Classifies one incoming byte as ASCII, lead, continuation or invalid and
// strips the marker bits.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_front (
   input  utf8v_pkg::req_item_type item,
   output utf8v_pkg::entry_type    entry
);
   import utf8v_pkg::*;

   always_comb begin
      entry.last = item.last_byte;
      entry.bits = 7'd0;
      if (item.text_byte inside {[8'h00:8'h7F]}) begin
         entry.cls  = BYTE_ASCII;
         entry.bits = item.text_byte[6:0];
      end else if (item.text_byte inside {[8'h80:8'hBF]}) begin
         entry.cls  = BYTE_CONT;
         entry.bits = {1'b0, item.text_byte[5:0]};
      end else if (item.text_byte inside {[8'hC0:8'hDF]}) begin
         entry.cls  = BYTE_LEAD2;
         entry.bits = {2'b00, item.text_byte[4:0]};
      end else if (item.text_byte inside {[8'hE0:8'hEF]}) begin
         entry.cls  = BYTE_LEAD3;
         entry.bits = {3'b000, item.text_byte[3:0]};
      end else if (item.text_byte inside {[8'hF0:8'hF7]}) begin
         entry.cls  = BYTE_LEAD4;
         entry.bits = {4'b0000, item.text_byte[2:0]};
      end else begin
         entry.cls  = BYTE_INVALID;
      end
   end

endmodule

`default_nettype wire

>>> rtl/utf8v_queue.sv
// ----------------------------------------------------------------------------
// utf8v_queue
// Small FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_queue #(
   parameter int DEPTH = utf8v_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  utf8v_pkg::entry_type push_entry,
   input  wire                  pop,
   output utf8v_pkg::slot_type  head,
   output logic                 full
);
   import utf8v_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_entry;
      end
   end

   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.entry = entries_ff[head_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue pop while empty");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

>>> rtl/utf8v_back.sv
// ----------------------------------------------------------------------------
// utf8v_back
// Decode state, character count, limit registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_back (
   input  wire                     clock,
   input  wire                     reset,
   input  utf8v_pkg::slot_type     head,
   output logic                    pop,
   input  wire                     csr_write_enable,
   input  wire                     csr_index,
   input  wire [3:0]               csr_write_data,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output utf8v_pkg::rsp_item_type rsp_payload
);
   import utf8v_pkg::*;

   logic [1:0]              pending_ff, pending_in;
   logic [CODEPOINT_W-1:0]  partial_ff, partial_in;
   logic [3:0]              count_ff, count_in;
   logic                    bad_ff, bad_in;
   logic                    foreign_ff, foreign_in;
   logic [3:0]              min_ff, max_ff;
   logic                    rsp_valid_ff;
   rsp_item_type            rsp_item_ff, rsp_item_in;

   // Take an item unless it closes a text and the result register is still full
   assign pop = head.valid && (!head.entry.last || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      logic [CODEPOINT_W-1:0] shifted;
      logic [CODEPOINT_W-1:0] cp;
      logic                   char_done;

      pending_in = pending_ff;
      partial_in = partial_ff;
      count_in   = count_ff;
      bad_in     = bad_ff;
      foreign_in = foreign_ff;
      char_done  = 1'b0;
      cp         = '0;
      shifted    = {partial_ff[CODEPOINT_W-7:0], head.entry.bits[5:0]};

      if (!bad_ff) begin
         if (pending_ff == 2'd0) begin
            case (head.entry.cls)
               BYTE_ASCII: begin
                  char_done = 1'b1;
                  cp        = {14'd0, head.entry.bits};
               end
               BYTE_LEAD2: begin
                  partial_in = {14'd0, head.entry.bits};
                  pending_in = 2'd1;
               end
               BYTE_LEAD3: begin
                  partial_in = {14'd0, head.entry.bits};
                  pending_in = 2'd2;
               end
               BYTE_LEAD4: begin
                  partial_in = {14'd0, head.entry.bits};
                  pending_in = 2'd3;
               end
               default: begin
                  bad_in = 1'b1;
               end
            endcase
         end else if (head.entry.cls == BYTE_CONT) begin
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               char_done  = 1'b1;
               cp         = shifted;
               partial_in = '0;
            end else begin
               partial_in = shifted;
            end
         end else begin
            bad_in = 1'b1;
         end
      end

      if (char_done) begin
         if (count_ff != CNT_MAX) begin
            count_in = count_ff + 4'd1;
         end
         if (!in_cjk(cp)) begin
            foreign_in = 1'b1;
         end
      end

      rsp_item_in.char_count = count_in;
      if (bad_in || pending_in != 2'd0) begin
         rsp_item_in.status = STATUS_BAD_UTF8;
      end else if (count_in < min_ff || count_in > max_ff) begin
         rsp_item_in.status = STATUS_BAD_LENGTH;
      end else if (foreign_in) begin
         rsp_item_in.status = STATUS_FOREIGN;
      end else begin
         rsp_item_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         partial_ff <= '0;
         count_ff   <= '0;
         bad_ff     <= 1'b0;
         foreign_ff <= 1'b0;
      end else if (pop) begin
         if (head.entry.last) begin
            // End of text: clear for the next one
            pending_ff <= '0;
            partial_ff <= '0;
            count_ff   <= '0;
            bad_ff     <= 1'b0;
            foreign_ff <= 1'b0;
         end else begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
            count_ff   <= count_in;
            bad_ff     <= bad_in;
            foreign_ff <= foreign_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_CHARS_RESET;
         max_ff <= MAX_CHARS_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_MIN_CHARS) begin
            min_ff <= csr_write_data;
         end
         if (csr_index == CSR_MAX_CHARS) begin
            max_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && head.entry.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.entry.last) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (pop && head.entry.last) |=>
         (pending_ff == 2'd0 && count_ff == 4'd0 && !bad_ff && !foreign_ff))
      else $error("state not cleared after end of text");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_MAX && !(pop && head.entry.last)) |=> count_ff == CNT_MAX)
      else $error("saturated character count changed");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(pop && head.entry.last))
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> rtl/utf8_cjk_text_validator_core.sv
// ----------------------------------------------------------------------------
// utf8_cjk_text_validator_core
// UTF-8 decoder and CJK ideograph text validator, one byte per item.
// ----------------------------------------------------------------------------
// The block takes a text one byte per cycle, with last_byte set on its final
// byte, and answers each text with one result: status (ok, bad UTF-8, length
// outside min_chars..max_chars, or a character outside the CJK ideograph
// ranges) and the character count, saturating at 15. It sustains one byte per
// clock while req_stall is low; the limit is the decode-state update in the
// back end. An accepted byte is written into the queue and decoded from its
// head; for a final byte the result is registered in the register that drives
// rsp_valid and rsp_payload. A two-entry queue between the byte classifier and
// the decoder keeps bytes flowing while a result waits on rsp_stall; req_stall
// rises only once the next final byte sits at the head of the queue and the
// queue has filled behind it. Overlong encodings pass.
// Write min_chars (index 0) and max_chars (index 1) only while idle.
`default_nettype none

module utf8_cjk_text_validator_core #(
   parameter int QUEUE_DEPTH = utf8v_pkg::QUEUE_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  utf8v_pkg::req_item_type req_payload,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output utf8v_pkg::rsp_item_type rsp_payload,
   input  wire                     csr_write_enable,
   input  wire                     csr_index,
   input  wire [3:0]               csr_write_data
);
   import utf8v_pkg::*;

   entry_type  front_entry;
   slot_type   queue_head;
   logic       queue_full;
   logic       push;
   logic       pop;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   utf8v_front u_front (
      .item  (req_payload),
      .entry (front_entry)
   );

   utf8v_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (queue_head),
      .full       (queue_full)
   );

   utf8v_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (queue_head),
      .pop              (pop),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

`default_nettype wire

>>> sim/utf8_cjk_text_validator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_cjk_text_validator_checker
// Watches the byte, result and register ports of the UTF-8 CJK validator,
// decodes each accepted byte in its own model of the text state and compares
// every accepted result, field by field, with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module utf8_cjk_text_validator_checker (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_stall,
   input  utf8v_pkg::req_item_type req_payload,
   input  wire                     rsp_valid,
   input  wire                     rsp_stall,
   input  utf8v_pkg::rsp_item_type rsp_payload,
   input  wire                     csr_write_enable,
   input  wire                     csr_index,
   input  wire [3:0]               csr_write_data,
   output int                      fail_count,
   output int                      pending_results
);

   import utf8v_pkg::*;

   logic [3:0]   min_limit;
   logic [3:0]   max_limit;
   logic [1:0]   conts_due;
   logic [20:0]  cp_acc;
   logic [3:0]   chars_seen;
   logic         enc_fault;
   logic         foreign_char;
   rsp_item_type verdict_queue[$];
   int           mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic is_cjk_ideograph(input logic [20:0] cp);
      return (cp >= 21'h03400 && cp <= 21'h04DBF) ||
             (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
             (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
             (cp >= 21'h20000 && cp <= 21'h2EBEF);
   endfunction

   task automatic clear_text();
      conts_due    = 2'd0;
      cp_acc       = 21'd0;
      chars_seen   = 4'd0;
      enc_fault    = 1'b0;
      foreign_char = 1'b0;
   endtask

   task automatic close_char(input logic [20:0] cp);
      if (chars_seen != CNT_MAX) begin
         chars_seen = chars_seen + 4'd1;
      end
      if (!is_cjk_ideograph(cp)) begin
         foreign_char = 1'b1;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b);
      // drop everything after a fault until the text ends
      if (enc_fault) begin
         return;
      end
      if (conts_due == 2'd0) begin
         if (b[7] == 1'b0) begin
            close_char({14'd0, b[6:0]});
         end else if (b[7:5] == 3'b110) begin
            cp_acc    = {16'd0, b[4:0]};
            conts_due = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            cp_acc    = {17'd0, b[3:0]};
            conts_due = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            cp_acc    = {18'd0, b[2:0]};
            conts_due = 2'd3;
         end else begin
            enc_fault = 1'b1;
         end
      end else if (b[7:6] != 2'b10) begin
         enc_fault = 1'b1;
      end else begin
         cp_acc    = {cp_acc[14:0], b[5:0]};
         conts_due = conts_due - 2'd1;
         if (conts_due == 2'd0) begin
            close_char(cp_acc);
            cp_acc = 21'd0;
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         min_limit = MIN_CHARS_RESET;
         max_limit = MAX_CHARS_RESET;
         clear_text();
         verdict_queue.delete();
      end else begin
         // compare first: a result never belongs to a byte taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch($sformatf("result with none pending (status %0d, count %0d)",
                                         rsp_payload.status, rsp_payload.char_count));
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_payload.status !== want.status) begin
                  report_mismatch($sformatf("status got %0d, expected %0d",
                                            rsp_payload.status, want.status));
               end
               if (rsp_payload.char_count !== want.char_count) begin
                  report_mismatch($sformatf("char_count got %0d, expected %0d",
                                            rsp_payload.char_count, want.char_count));
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_payload.text_byte);
            if (req_payload.last_byte) begin
               if (enc_fault || conts_due != 2'd0) begin
                  want.status = STATUS_BAD_UTF8;
               end else if (chars_seen < min_limit || chars_seen > max_limit) begin
                  want.status = STATUS_BAD_LENGTH;
               end else if (foreign_char) begin
                  want.status = STATUS_FOREIGN;
               end else begin
                  want.status = STATUS_OK;
               end
               want.char_count = chars_seen;
               verdict_queue = {verdict_queue, want};
               clear_text();
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_MIN_CHARS) begin
               min_limit = csr_write_data;
            end else if (csr_index == CSR_MAX_CHARS) begin
               max_limit = csr_write_data;
            end
         end
      end
      pending_results = verdict_queue.size();
   end

endmodule

>>> sim/utf8_cjk_text_validator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_cjk_text_validator_core_tb
// Feeds byte streams of UTF-8 texts into the validator: a short directed set,
// then random texts of CJK, ASCII, other and overlong characters, with bad
// lead bytes, bad continuations and cut-short endings mixed in. Runs several
// length limits and idling patterns; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module utf8_cjk_text_validator_core_tb;

   import utf8v_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_payload;
   logic         csr_write_enable = 1'b0;
   logic         csr_index = CSR_MIN_CHARS;
   logic [3:0]   csr_write_data = 4'd0;

   int fail_count;
   int pending_results;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic hold_request = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;
   int   cycle_count = 0;

   logic [7:0] text_bytes[$];

   always #10 clock = ~clock;

   utf8_cjk_text_validator_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   utf8_cjk_text_validator_checker verdict_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_results  (pending_results)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold per pressure phase
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end
      if (!hold_request) begin
         hold_taken <= 1'b0;
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
   end

   function automatic logic [20:0] cjk_sample(input logic [20:0] lo, input logic [20:0] hi);
      case ($urandom_range(9))
         0: return lo - 21'd1;
         1: return lo;
         2: return hi;
         3: return hi + 21'd1;
         default: return 21'($urandom_range(hi, lo));
      endcase
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      text_bytes = {text_bytes, b};
   endfunction

   // encode in exactly nb bytes; short values in long forms come out overlong
   function automatic void encode_cp(input logic [20:0] cp, input int nb);
      case (nb)
         1: append_byte({1'b0, cp[6:0]});
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic void add_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 14)      encode_cp(cjk_sample(21'h04E00, 21'h09FFF), 3);
      else if (pick < 24) encode_cp(cjk_sample(21'h03400, 21'h04DBF), 3);
      else if (pick < 32) encode_cp(cjk_sample(21'h0F900, 21'h0FAFF), 3);
      else if (pick < 46) encode_cp(cjk_sample(21'h20000, 21'h2EBEF), 4);
      else if (pick < 60) encode_cp(21'($urandom_range(127)), 1);
      else if (pick < 68) encode_cp(21'($urandom_range(21'h7FF)), 2);
      else if (pick < 78) encode_cp(21'($urandom_range(21'hFFFF)), 3);
      else if (pick < 88) encode_cp(21'($urandom_range(21'h1FFFFF)), 4);
      else                encode_cp(cjk_sample(21'h04E00, 21'h09FFF), 4);
   endfunction

   function automatic void build_text();
      int         mode;
      int         nb;
      int         idx;
      logic [7:0] b;
      text_bytes.delete();
      mode = $urandom_range(99);
      if (mode < 8) begin
         repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 20)) add_char();
      end else begin
         repeat ($urandom_range(1, 10)) add_char();
      end
      if (mode < 14) begin
         // stray continuation or a byte that can never lead
         b = $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                               : 8'($urandom_range(8'hFF, 8'hF8));
         text_bytes.insert($urandom_range(text_bytes.size()), b);
      end else if (mode < 20) begin
         idx = -1;
         foreach (text_bytes[i]) begin
            if (text_bytes[i][7:6] == 2'b10 && $urandom_range(2) == 0) idx = i;
         end
         b = 8'($urandom_range(255));
         if (b[7:6] == 2'b10) b[6] = 1'b1;
         if (idx >= 0) begin
            text_bytes[idx] = b;
         end else begin
            append_byte(8'hE5);
            append_byte(b);
         end
      end else if (mode < 26) begin
         // cut the last sequence short
         nb = $urandom_range(2, 4);
         case (nb)
            2: append_byte({3'b110, 5'($urandom_range(31))});
            3: append_byte({4'b1110, 4'($urandom_range(15))});
            default: append_byte({5'b11110, 3'($urandom_range(7))});
         endcase
         repeat ($urandom_range(nb - 2)) append_byte({2'b10, 6'($urandom_range(63))});
      end
   endfunction

   task automatic send_item(input req_item_type item);
      if (send_idle_pct != 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_payload = item;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_text();
      req_item_type item;
      foreach (text_bytes[i]) begin
         item.text_byte = text_bytes[i];
         item.last_byte = (i == text_bytes.size() - 1);
         send_item(item);
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [3:0] value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic run_phase(input logic [3:0] lo, input logic [3:0] hi, input int send_pct,
                            input int rcv_pct, input logic pressure, input int n_bytes);
      int sent;
      sent = 0;
      drain();
      csr_write(CSR_MIN_CHARS, lo);
      csr_write(CSR_MAX_CHARS, hi);
      send_idle_pct = send_pct;
      stall_pct     = rcv_pct;
      hold_request  = pressure;
      while (sent < n_bytes) begin
         build_text();
         send_text();
         sent += text_bytes.size();
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // limits 2..8 out of reset
      text_bytes = '{8'hE4, 8'hB8, 8'h80, 8'hE9, 8'hBF, 8'hBF};
      send_text();
      text_bytes = '{8'hF0, 8'hA0, 8'h80, 8'h80, 8'hF0, 8'hAE, 8'hBA, 8'hAF};
      send_text();
      text_bytes = '{8'h80};
      send_text();
      text_bytes = '{8'h7F, 8'hFF};
      send_text();
      text_bytes = '{8'hE3, 8'h90, 8'h80, 8'h41};
      send_text();
      text_bytes = '{8'hC0, 8'h80, 8'hC2};
      send_text();
      text_bytes = '{8'hE4, 8'h41};
      send_text();

      run_phase(4'd1, 4'd15, 0, 0, 1'b0, 300);
      run_phase(4'd15, 4'd15, 54, 0, 1'b0, 300);
      run_phase(4'd10, 4'd4, 0, 54, 1'b0, 300);
      run_phase(4'd1, 4'd1, 14, 14, 1'b0, 300);
      run_phase(4'd3, 4'd8, 0, 0, 1'b1, 200);
      run_phase(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)), 14, 14, 1'b0, 300);

      drain();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/utf8v_pkg.sv
rtl/utf8v_front.sv
rtl/utf8v_queue.sv
rtl/utf8v_back.sv
rtl/utf8_cjk_text_validator_core.sv
sim/utf8_cjk_text_validator_checker.sv
sim/utf8_cjk_text_validator_core_tb.sv
